// ----- design/sdfr_pkg.sv -----
// Shared types and constants for the serial dimmer frame receiver.
package sdfr_pkg;

  localparam int BYTE_W = 8;
  localparam int PIN_W  = 18;
  localparam int CFG_IDX_W = 3;

  // Values stored for the three escaped codes.
  localparam logic [BYTE_W-1:0] ESC_VAL_LOW  = 8'h7D;
  localparam logic [BYTE_W-1:0] ESC_VAL_MID  = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_VAL_HIGH = 8'h7F;

  // Reset values of the configuration registers.
  localparam logic [BYTE_W-1:0] RST_SYNC      = 8'd126;
  localparam logic [BYTE_W-1:0] RST_PAD       = 8'd125;
  localparam logic [BYTE_W-1:0] RST_ESC       = 8'd127;
  localparam logic [BYTE_W-1:0] RST_CODE_LOW  = 8'd47;
  localparam logic [BYTE_W-1:0] RST_CODE_MID  = 8'd48;
  localparam logic [BYTE_W-1:0] RST_CODE_HIGH = 8'd49;
  localparam logic [BYTE_W-1:0] RST_ADDR      = 8'd128;

  // Reset value of the PWM counter, so the first tick wraps to zero.
  localparam logic [BYTE_W-1:0] PWM_CNT_RST = 8'hFF;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC      = 3'd0,
    REG_PAD       = 3'd1,
    REG_ESC       = 3'd2,
    REG_CODE_LOW  = 3'd3,
    REG_CODE_MID  = 3'd4,
    REG_CODE_HIGH = 3'd5,
    REG_ADDR      = 3'd6,
    REG_POLARITY  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_byte;
    logic [BYTE_W-1:0] pad_byte;
    logic [BYTE_W-1:0] escape_byte;
    logic [BYTE_W-1:0] escape_code_low;
    logic [BYTE_W-1:0] escape_code_mid;
    logic [BYTE_W-1:0] escape_code_high;
    logic [BYTE_W-1:0] device_address;
    logic              sink_polarity;
  } cfg_t;

  // Classified word passed from the front end to the back end.
  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] rx_byte;
    logic              is_sync;
    logic              is_pad;
    logic              is_esc;
    logic              is_addr;
    logic              above_addr;
    logic              code_low;
    logic              code_mid;
    logic              code_high;
  } item_t;

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic [PIN_W-1:0]  pin_levels;
    logic              frame_done;
  } result_t;

endpackage

// ----- design/serial_dimmer_frame_receiver_pwm.sv -----
// Top level of the serial dimmer frame receiver with PWM outputs.
//
//   Channel  Direction  Word contents
//   in_      slave      tdata: rx_byte; tuser: mode (0 byte, 1 tick)
//   out_     master     tdata: tx_byte, pin_levels; tuser: tx_valid; tlast: frame_done
//   cfg_     write      cfg_index selects the register, cfg_wdata its value
//
// One word is accepted per cycle while the queue has room. It is written into
// the two-entry queue, then the back end parses it or runs the PWM step while
// loading the output register, from which its result is offered.
// Reset is synchronous on rst_n low and clears parser, PWM and channel state.
// A stall on out_ fills the queue and then drops in_tready.
module serial_dimmer_frame_receiver_pwm #(
  parameter int CHANNELS = 18
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input words.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] rx_byte
  input  logic                           in_tuser,   // [0] mode
  // Result words.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // [7:0] tx_byte, [25:8] pin_levels
  output logic                           out_tuser,  // [0] tx_valid
  output logic                           out_tlast,  // frame_done
  // Configuration writes.
  input  logic                           cfg_we,
  input  logic [sdfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdfr_pkg::BYTE_W-1:0]    cfg_wdata
);

  sdfr_pkg::cfg_t    cfg;
  sdfr_pkg::item_t   push_item;
  sdfr_pkg::item_t   head_item;
  sdfr_pkg::result_t result;
  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;

  sdfr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  sdfr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_i     (cfg),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_item_o  (push_item)
  );

  sdfr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  sdfr_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg),
    .q_valid_i    (q_valid),
    .q_item_i     (head_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_tvalid),
    .out_ready_i  (out_tready),
    .out_result_o (result)
  );

  // Pack the result word.
  assign out_tdata = {6'd0, result.pin_levels, result.tx_byte};
  assign out_tuser = result.tx_valid;
  assign out_tlast = result.frame_done;

endmodule

// ----- design/sdfr_cfg.sv -----
// Configuration register file written through the plain write port.
module sdfr_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sdfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdfr_pkg::BYTE_W-1:0]    cfg_wdata,
  output sdfr_pkg::cfg_t                 cfg_o
);

  sdfr_pkg::cfg_t cfg_r;

  // Register writes, one register per index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_byte        <= sdfr_pkg::RST_SYNC;
      cfg_r.pad_byte         <= sdfr_pkg::RST_PAD;
      cfg_r.escape_byte      <= sdfr_pkg::RST_ESC;
      cfg_r.escape_code_low  <= sdfr_pkg::RST_CODE_LOW;
      cfg_r.escape_code_mid  <= sdfr_pkg::RST_CODE_MID;
      cfg_r.escape_code_high <= sdfr_pkg::RST_CODE_HIGH;
      cfg_r.device_address   <= sdfr_pkg::RST_ADDR;
      cfg_r.sink_polarity    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdfr_pkg::REG_SYNC:      cfg_r.sync_byte        <= cfg_wdata;
        sdfr_pkg::REG_PAD:       cfg_r.pad_byte         <= cfg_wdata;
        sdfr_pkg::REG_ESC:       cfg_r.escape_byte      <= cfg_wdata;
        sdfr_pkg::REG_CODE_LOW:  cfg_r.escape_code_low  <= cfg_wdata;
        sdfr_pkg::REG_CODE_MID:  cfg_r.escape_code_mid  <= cfg_wdata;
        sdfr_pkg::REG_CODE_HIGH: cfg_r.escape_code_high <= cfg_wdata;
        sdfr_pkg::REG_ADDR:      cfg_r.device_address   <= cfg_wdata;
        sdfr_pkg::REG_POLARITY:  cfg_r.sink_polarity    <= cfg_wdata[0];
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ----- design/sdfr_front.sv -----
// Front end: accepts input words and classifies received bytes.
module sdfr_front (
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [sdfr_pkg::BYTE_W-1:0] in_tdata,
  input  logic                        in_tuser,
  input  sdfr_pkg::cfg_t              cfg_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output sdfr_pkg::item_t             q_item_o
);

  // Accept whenever the queue has room.
  assign in_tready = !q_full_i;
  assign q_push_o  = in_tvalid && !q_full_i;

  // Compare the byte against every programmed marker in parallel.
  always_comb begin
    q_item_o.mode       = in_tuser;
    q_item_o.rx_byte    = in_tdata;
    q_item_o.is_sync    = (in_tdata == cfg_i.sync_byte);
    q_item_o.is_pad     = (in_tdata == cfg_i.pad_byte);
    q_item_o.is_esc     = (in_tdata == cfg_i.escape_byte);
    q_item_o.is_addr    = (in_tdata == cfg_i.device_address);
    q_item_o.above_addr = (in_tdata > cfg_i.device_address);
    q_item_o.code_low   = (in_tdata == cfg_i.escape_code_low);
    q_item_o.code_mid   = (in_tdata == cfg_i.escape_code_mid);
    q_item_o.code_high  = (in_tdata == cfg_i.escape_code_high);
  end

endmodule

// ----- design/sdfr_queue.sv -----
// Two-entry queue of classified words between front and back end.
module sdfr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_i,
  input  sdfr_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output sdfr_pkg::item_t item_o
);

  sdfr_pkg::item_t mem_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;
  logic [1:0]      count_nxt;

  assign full_o  = (count_r == 2'd2);
  assign valid_o = (count_r != 2'd0);
  assign item_o  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r + {1'b0, push_i} - {1'b0, pop_i};
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_r <= !wr_ptr_r;
      if (pop_i)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= item_i;
  end

endmodule

// ----- design/sdfr_back.sv -----
// Back end: frame parser, PWM engine and output register.
module sdfr_back #(
  parameter int CHANNELS = 18
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sdfr_pkg::cfg_t    cfg_i,
  input  logic              q_valid_i,
  input  sdfr_pkg::item_t   q_item_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sdfr_pkg::result_t out_result_o
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);
  localparam int WIDE_W = (CHANNELS > sdfr_pkg::PIN_W) ? CHANNELS : sdfr_pkg::PIN_W;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_CMD,
    PH_CAPTURE,
    PH_ESCAPED
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [sdfr_pkg::BYTE_W-1:0] pend_r [CHANNELS];
  logic [sdfr_pkg::BYTE_W-1:0] act_r  [CHANNELS];
  logic [sdfr_pkg::BYTE_W-1:0] cnt_r, cnt_nxt;
  logic [CHANNELS-1:0]         next_r, next_nxt;
  logic [CHANNELS-1:0]         shown_r, shown_nxt;
  logic                        out_valid_r;
  sdfr_pkg::result_t           out_r, out_nxt;

  logic                        wrap;
  logic [CHANNELS-1:0]         match;
  logic                        slot_used;
  logic                        pend_we;
  logic [sdfr_pkg::BYTE_W-1:0] pend_val;
  logic [CHANNELS-1:0]         pin_on;
  logic [WIDE_W-1:0]           pin_wide;

  // Take a word whenever the output register is free or being emptied.
  assign q_pop_o = q_valid_i && (!out_valid_r || out_ready_i);

  // Per-channel compare; at wrap the pending values are the ones in force.
  assign cnt_nxt = q_item_i.mode ? (cnt_r + 8'd1) : cnt_r;
  assign wrap    = q_item_i.mode && (cnt_nxt == '0);

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      match[i] = ((wrap ? pend_r[i] : act_r[i]) == cnt_nxt);
    end
  end

  // Parser and tick handling for the word at the head of the queue.
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    slot_used = 1'b0;
    pend_we   = 1'b0;
    pend_val  = q_item_i.rx_byte;
    shown_nxt = shown_r;
    next_nxt  = next_r;
    out_nxt.tx_valid   = 1'b0;
    out_nxt.tx_byte    = '0;
    out_nxt.frame_done = 1'b0;

    if (q_item_i.mode) begin
      shown_nxt = next_r;
      next_nxt  = (wrap ? '0 : next_r) | match;
    end else begin
      unique case (phase_r)
        PH_HUNT: begin
          out_nxt.tx_valid = 1'b1;
          out_nxt.tx_byte  = q_item_i.rx_byte;
          if (q_item_i.is_sync) phase_nxt = PH_CMD;
        end
        PH_CMD: begin
          if (q_item_i.is_addr) begin
            idx_nxt   = '0;
            phase_nxt = PH_CAPTURE;
          end else begin
            out_nxt.tx_valid = 1'b1;
            out_nxt.tx_byte  = q_item_i.above_addr ? (q_item_i.rx_byte - 8'd1)
                                                   : q_item_i.rx_byte;
            phase_nxt = PH_HUNT;
          end
        end
        PH_CAPTURE: begin
          priority if (q_item_i.is_pad) begin
            // Filler is dropped.
          end else if (q_item_i.is_esc) begin
            phase_nxt = PH_ESCAPED;
          end else begin
            slot_used = 1'b1;
            pend_we   = 1'b1;
          end
        end
        PH_ESCAPED: begin
          // An unknown code still uses up its channel slot.
          slot_used = 1'b1;
          priority if (q_item_i.code_low) begin
            pend_we  = 1'b1;
            pend_val = sdfr_pkg::ESC_VAL_LOW;
          end else if (q_item_i.code_mid) begin
            pend_we  = 1'b1;
            pend_val = sdfr_pkg::ESC_VAL_MID;
          end else if (q_item_i.code_high) begin
            pend_we  = 1'b1;
            pend_val = sdfr_pkg::ESC_VAL_HIGH;
          end else begin
            pend_we  = 1'b0;
          end
        end
      endcase

      if (slot_used) begin
        if (idx_r == LAST_IDX) begin
          idx_nxt            = '0;
          phase_nxt          = PH_HUNT;
          out_nxt.frame_done = 1'b1;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          phase_nxt = PH_CAPTURE;
        end
      end
    end

    // Pin levels from the on-mask and the sink polarity.
    pin_on   = cfg_i.sink_polarity ? shown_nxt : ~shown_nxt;
    pin_wide = WIDE_W'(pin_on);
    out_nxt.pin_levels = pin_wide[sdfr_pkg::PIN_W-1:0];
  end

  // State, value stores and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      idx_r       <= '0;
      cnt_r       <= sdfr_pkg::PWM_CNT_RST;
      next_r      <= '0;
      shown_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        pend_r[i] <= '0;
        act_r[i]  <= '0;
      end
    end else begin
      out_valid_r <= q_pop_o || (out_valid_r && !out_ready_i);
      if (q_pop_o) begin
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
        cnt_r   <= cnt_nxt;
        next_r  <= next_nxt;
        shown_r <= shown_nxt;
        out_r   <= out_nxt;
        if (pend_we) pend_r[idx_r] <= pend_val;
        if (wrap) begin
          for (int i = 0; i < CHANNELS; i++) act_r[i] <= pend_r[i];
        end
      end
    end
  end

  assign out_valid_o  = out_valid_r;
  assign out_result_o = out_r;

endmodule

// ----- design/sdfr_checker.sv -----
// Port-level assertions for the receiver and their bind to the top level.
module sdfr_checker #(
  parameter int CHANNELS = 18
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  localparam int MASK_W = (CHANNELS < sdfr_pkg::PIN_W) ? CHANNELS : sdfr_pkg::PIN_W;
  localparam logic [sdfr_pkg::PIN_W-1:0] PIN_MASK =
    sdfr_pkg::PIN_W'((64'd1 << MASK_W) - 64'd1);

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result word changed while stalled");

  // No retransmit means an empty byte field.
  a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[7:0] == 8'd0)
    else $error("tx byte set without tx flag");

  // A byte that completes a frame is never retransmitted.
  a_done_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tuser)
    else $error("frame end with retransmit");

  // Pins of absent channels stay low.
  a_pin_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[25:8] & ~PIN_MASK) == '0)
    else $error("pin set beyond channel count");

  // Nothing is offered right after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

endmodule

bind serial_dimmer_frame_receiver_pwm sdfr_checker #(
  .CHANNELS (CHANNELS)
) u_sdfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- verif/tb_serial_dimmer_frame_receiver_pwm.sv -----
// Self-checking testbench for the serial dimmer frame receiver with PWM outputs.
`timescale 1ns / 100ps

module tb_serial_dimmer_frame_receiver_pwm;

  localparam int NUM_CH = 18;
  localparam int RUN_LIMIT = 400000;
  localparam int MAX_PRINTS = 40;

  typedef enum logic [1:0] {PH_HUNT, PH_CMD, PH_CAPTURE, PH_ESCAPED} parse_phase_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata = '0;   // [7:0] rx_byte
  logic                           in_tuser = 1'b0; // [0] mode
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [31:0]                    out_tdata;       // [7:0] tx_byte, [25:8] pin_levels
  logic                           out_tuser;       // [0] tx_valid
  logic                           out_tlast;       // frame_done
  logic                           cfg_we = 1'b0;
  logic [sdfr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sdfr_pkg::BYTE_W-1:0]    cfg_wdata = '0;

  // Shadow of the block: configuration, parser and PWM state.
  sdfr_pkg::cfg_t             cfg_shadow;
  parse_phase_t               phase;
  int unsigned                slot;
  logic [7:0]                 pending_lvl [NUM_CH];
  logic [7:0]                 active_lvl [NUM_CH];
  logic [7:0]                 pwm_cnt;
  logic [sdfr_pkg::PIN_W-1:0] lit_next;
  logic [sdfr_pkg::PIN_W-1:0] lit_shown;
  sdfr_pkg::result_t          expected_q[$];

  // Byte sequence waiting to be sent by the random traffic generator.
  logic [7:0] frame_bytes[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int mismatches = 0;
  int words_sent = 0;
  int ticks_sent = 0;
  int words_checked = 0;
  int frames_seen = 0;
  int cycle_count = 0;

  serial_dimmer_frame_receiver_pwm #(.CHANNELS(NUM_CH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit, counted in clock cycles.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_serial_dimmer_frame_receiver_pwm NOT OK");
      $finish;
    end
  end

  // Receiver: a long hold-off when requested, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at result word %0d: %s is %0h, expected %0h",
               words_checked, what, got, want);
  endtask

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin
    sdfr_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", out_tdata, 32'd0);
      end else begin
        want = expected_q.pop_front();
        if (out_tuser !== want.tx_valid)
          report_mismatch("tx_valid", 32'(out_tuser), 32'(want.tx_valid));
        if (out_tdata[7:0] !== want.tx_byte)
          report_mismatch("tx_byte", 32'(out_tdata[7:0]), 32'(want.tx_byte));
        if (out_tdata[8 +: sdfr_pkg::PIN_W] !== want.pin_levels)
          report_mismatch("pin_levels", 32'(out_tdata[8 +: sdfr_pkg::PIN_W]),
                          32'(want.pin_levels));
        if (out_tlast !== want.frame_done)
          report_mismatch("frame_done", 32'(out_tlast), 32'(want.frame_done));
      end
      words_checked++;
      if (out_tlast === 1'b1) frames_seen++;
    end
  end

  task automatic reset_shadow();
    cfg_shadow.sync_byte        = sdfr_pkg::RST_SYNC;
    cfg_shadow.pad_byte         = sdfr_pkg::RST_PAD;
    cfg_shadow.escape_byte      = sdfr_pkg::RST_ESC;
    cfg_shadow.escape_code_low  = sdfr_pkg::RST_CODE_LOW;
    cfg_shadow.escape_code_mid  = sdfr_pkg::RST_CODE_MID;
    cfg_shadow.escape_code_high = sdfr_pkg::RST_CODE_HIGH;
    cfg_shadow.device_address   = sdfr_pkg::RST_ADDR;
    cfg_shadow.sink_polarity    = 1'b0;
    phase = PH_HUNT;
    slot = 0;
    foreach (pending_lvl[i]) pending_lvl[i] = '0;
    foreach (active_lvl[i]) active_lvl[i] = '0;
    pwm_cnt = sdfr_pkg::PWM_CNT_RST;
    lit_next = '0;
    lit_shown = '0;
  endtask

  // Use up one channel slot; the last slot ends the frame.
  task automatic store_slot(input logic [7:0] v, input bit write, output bit done);
    if (write) pending_lvl[slot] = v;
    slot++;
    done = 1'b0;
    if (slot >= NUM_CH) begin
      slot = 0;
      phase = PH_HUNT;
      done = 1'b1;
    end else begin
      phase = PH_CAPTURE;
    end
  endtask

  // Advance the shadow by one accepted word and queue the result it causes.
  task automatic predict_word(input bit tick, input logic [7:0] b);
    sdfr_pkg::result_t r;
    bit                done;
    bit                txv;
    logic [7:0]        txb;
    done = 1'b0;
    txv = 1'b0;
    txb = '0;
    if (tick) begin
      lit_shown = lit_next;
      pwm_cnt = pwm_cnt + 8'd1;
      if (pwm_cnt == 8'd0) begin
        active_lvl = pending_lvl;
        lit_next = '0;
      end
      for (int i = 0; i < NUM_CH; i++)
        if (active_lvl[i] == pwm_cnt) lit_next[i] = 1'b1;
    end else begin
      case (phase)
        PH_HUNT: begin
          txv = 1'b1;
          txb = b;
          if (b == cfg_shadow.sync_byte) phase = PH_CMD;
        end
        PH_CMD: begin
          if (b == cfg_shadow.device_address) begin
            slot = 0;
            phase = PH_CAPTURE;
          end else begin
            txv = 1'b1;
            txb = (b > cfg_shadow.device_address) ? b - 8'd1 : b;
            phase = PH_HUNT;
          end
        end
        PH_CAPTURE: begin
          // Pad bytes leave the parser untouched.
          if (b == cfg_shadow.pad_byte) begin
          end else if (b == cfg_shadow.escape_byte) begin
            phase = PH_ESCAPED;
          end else begin
            store_slot(b, 1'b1, done);
          end
        end
        default: begin
          // An unknown code still uses up its slot.
          if (b == cfg_shadow.escape_code_low)
            store_slot(sdfr_pkg::ESC_VAL_LOW, 1'b1, done);
          else if (b == cfg_shadow.escape_code_mid)
            store_slot(sdfr_pkg::ESC_VAL_MID, 1'b1, done);
          else if (b == cfg_shadow.escape_code_high)
            store_slot(sdfr_pkg::ESC_VAL_HIGH, 1'b1, done);
          else
            store_slot(8'h00, 1'b0, done);
        end
      endcase
    end
    r.tx_valid   = txv;
    r.tx_byte    = txb;
    r.pin_levels = cfg_shadow.sink_polarity ? lit_shown : ~lit_shown;
    r.frame_done = done;
    expected_q.push_back(r);
  endtask

  // Offer one word after a random idle gap and wait until it is taken.
  task automatic send_word(input bit tick, input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tuser  <= 1'($urandom);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= tick;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_word(tick, b);
    words_sent++;
    if (tick) ticks_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) send_word(1'b0, seq[i]);
  endtask

  // Stop offering and wait until every expected word has come back.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input sdfr_pkg::cfg_reg_t idx, input logic [7:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sdfr_pkg::REG_SYNC:      cfg_shadow.sync_byte        = v;
      sdfr_pkg::REG_PAD:       cfg_shadow.pad_byte         = v;
      sdfr_pkg::REG_ESC:       cfg_shadow.escape_byte      = v;
      sdfr_pkg::REG_CODE_LOW:  cfg_shadow.escape_code_low  = v;
      sdfr_pkg::REG_CODE_MID:  cfg_shadow.escape_code_mid  = v;
      sdfr_pkg::REG_CODE_HIGH: cfg_shadow.escape_code_high = v;
      sdfr_pkg::REG_ADDR:      cfg_shadow.device_address   = v;
      default:                 cfg_shadow.sink_polarity    = v[0];
    endcase
  endtask

  task automatic apply_setting(input logic [7:0] sync_b, input logic [7:0] pad_b,
                               input logic [7:0] esc_b, input logic [7:0] lo,
                               input logic [7:0] mid, input logic [7:0] hi,
                               input logic [7:0] addr, input bit pol);
    write_reg(sdfr_pkg::REG_SYNC, sync_b);
    write_reg(sdfr_pkg::REG_PAD, pad_b);
    write_reg(sdfr_pkg::REG_ESC, esc_b);
    write_reg(sdfr_pkg::REG_CODE_LOW, lo);
    write_reg(sdfr_pkg::REG_CODE_MID, mid);
    write_reg(sdfr_pkg::REG_CODE_HIGH, hi);
    write_reg(sdfr_pkg::REG_ADDR, addr);
    write_reg(sdfr_pkg::REG_POLARITY, {7'd0, pol});
  endtask

  // Queue one channel value, sometimes padded, escaped or with a bad code.
  task automatic queue_value();
    int r;
    r = $urandom_range(99);
    if (r < 10) frame_bytes.push_back(cfg_shadow.pad_byte);
    if (r < 30) begin
      frame_bytes.push_back(cfg_shadow.escape_byte);
      case ($urandom_range(3))
        0:       frame_bytes.push_back(cfg_shadow.escape_code_low);
        1:       frame_bytes.push_back(cfg_shadow.escape_code_mid);
        2:       frame_bytes.push_back(cfg_shadow.escape_code_high);
        default: frame_bytes.push_back(8'($urandom));
      endcase
    end else if (r < 36) begin
      frame_bytes.push_back($urandom_range(1) ? 8'hFF : 8'h00);
    end else begin
      frame_bytes.push_back(8'($urandom));
    end
  endtask

  // Mostly well-formed frames with random content, some noise and short frames.
  task automatic queue_sequence();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
    end else begin
      frame_bytes.push_back(cfg_shadow.sync_byte);
      if ($urandom_range(99) < 80) begin
        frame_bytes.push_back(cfg_shadow.device_address);
        n = (kind < 20) ? $urandom_range(1, NUM_CH - 1) : NUM_CH;
        repeat (n) queue_value();
      end else begin
        frame_bytes.push_back(8'($urandom));
      end
    end
  endtask

  // Random words: ticks mixed into the byte stream.
  task automatic random_traffic(input int count);
    for (int k = 0; k < count; k++) begin
      if (frame_bytes.size() == 0) queue_sequence();
      if ($urandom_range(99) < 35) send_word(1'b1, 8'($urandom));
      else send_word(1'b0, frame_bytes.pop_front());
    end
  endtask

  // Parser cases with the reset register values.
  task automatic test_parser_cases();
    send_bytes('{8'h00, 8'hFF, 8'h7E, 8'h81, 8'h7E, 8'h00, 8'h7E, 8'h7E});
    // Capture: pad, the three escapes, escapes followed by pad, sync and escape.
    send_bytes('{8'h7E, 8'h80, 8'h7D, 8'h7F, 8'h2F, 8'h7F, 8'h30, 8'h7F, 8'h31,
                 8'h7F, 8'h7D, 8'h7F, 8'h7E, 8'h7F, 8'h7F, 8'h7E});
    // A tick in the middle of capture, then the remaining slots.
    send_word(1'b1, 8'hA5);
    send_bytes('{8'h00, 8'hFF});
    for (int i = 1; i <= 9; i++) send_word(1'b0, 8'(i));
    send_word(1'b0, 8'h55);
    settle();
  endtask

  // A full frame of distinct levels, then more than one PWM period of ticks.
  task automatic test_pwm_wrap();
    send_bytes('{8'h7E, 8'h80, 8'd0, 8'd1, 8'd2, 8'd255, 8'd254, 8'd128, 8'd64,
                 8'd32, 8'd16, 8'd8, 8'd4, 8'd3, 8'd200, 8'd100, 8'd50, 8'd25,
                 8'd12, 8'd6});
    repeat (260) send_word(1'b1, 8'($urandom));
    settle();
  endtask

  // The receiver holds off long enough for the block to stop taking words.
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 300;
    random_traffic(80);
    settle();
  endtask

  // Random traffic under several register settings and idling patterns.
  task automatic test_register_settings();
    for (int s = 0; s < 5; s++) begin
      case (s)
        1: apply_setting(8'h00, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h00, 1'b1);
        2: apply_setting(8'hFF, 8'h00, 8'hFE, 8'hFF, 8'h00, 8'h80, 8'hFF, 1'b0);
        3: apply_setting(8'h30, 8'h20, 8'h21, 8'h10, 8'h10, 8'h10, 8'h30, 1'b1);
        4: apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
        default: ;
      endcase
      for (int p = 0; p < 4; p++) begin
        idle_pct  = (p == 1) ? 75 : (p == 3) ? 33 : 0;
        stall_pct = (p == 2) ? 75 : (p == 3) ? 33 : 0;
        random_traffic(55);
      end
      frame_bytes.delete();
      settle();
    end
  endtask

  initial begin
    reset_shadow();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_parser_cases();
    test_pwm_wrap();
    test_backpressure();
    test_register_settings();
    settle();

    $display("sent %0d words (%0d PWM ticks) over five register settings", words_sent,
             ticks_sent);
    $display("checked %0d result words, %0d completed frames, %0d mismatches",
             words_checked, frames_seen, mismatches);
    if (expected_q.size() != 0)
      report_mismatch("results never received", 32'(expected_q.size()), 32'd0);
    if (mismatches == 0) begin
      $display("tb_serial_dimmer_frame_receiver_pwm OK");
    end else begin
      $display("tb_serial_dimmer_frame_receiver_pwm NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/sdfr_pkg.sv
design/sdfr_cfg.sv
design/sdfr_front.sv
design/sdfr_queue.sv
design/sdfr_back.sv
design/serial_dimmer_frame_receiver_pwm.sv
design/sdfr_checker.sv
verif/tb_serial_dimmer_frame_receiver_pwm.sv
